// ===== rtl/lthc_pkg.sv =====
// package for the lift toggle/hold controller: types, register map, constants
`timescale 1ns / 1ps

package lthc_pkg;

    // register map
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_POSITION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_POSITION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SLOW_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IN_SLOW_ZONE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_MS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SETTLE_MS    = 3'd6;

    // field widths
    localparam int unsigned POS_W   = 13;
    localparam int unsigned VEL_W   = 9;
    localparam int unsigned CPOS_W  = 12;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned POWER_W = 8;
    localparam int unsigned MODE_W  = 2;

    // reset values of the configuration registers
    localparam logic [TICK_W-1:0]  TICK_MS_RST          = 8'd10;
    localparam logic [CPOS_W-1:0]  NEUTRAL_POSITION_RST = 12'd360;
    localparam logic [CPOS_W-1:0]  OUT_POSITION_RST     = 12'd575;
    localparam logic [CPOS_W-1:0]  OUT_SLOW_MARGIN_RST  = 12'd100;
    localparam logic [CPOS_W-1:0]  IN_SLOW_ZONE_RST     = 12'd150;
    localparam logic [TIMER_W-1:0] HOLD_TIME_MS_RST     = 16'd300;
    localparam logic [TIMER_W-1:0] OUT_SETTLE_MS_RST    = 16'd500;

    // drive power levels
    localparam logic signed [POWER_W-1:0] PWR_UP_FAST  = -8'sd127;
    localparam logic signed [POWER_W-1:0] PWR_UP_SLOW  = -8'sd60;
    localparam logic signed [POWER_W-1:0] PWR_OUT_FAST = 8'sd127;
    localparam logic signed [POWER_W-1:0] PWR_OUT_SLOW = 8'sd20;
    localparam logic signed [POWER_W-1:0] PWR_STOP     = 8'sd0;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    // lift mode codes
    localparam logic [MODE_W-1:0] LIFT_UP      = 2'd0;
    localparam logic [MODE_W-1:0] LIFT_OUT     = 2'd1;
    localparam logic [MODE_W-1:0] LIFT_NEUTRAL = 2'd2;

    // drive mode codes
    localparam logic DRIVE_POWER  = 1'b0;
    localparam logic DRIVE_TARGET = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_ms;
        logic [CPOS_W-1:0]  neutral_position;
        logic [CPOS_W-1:0]  out_position;
        logic [CPOS_W-1:0]  out_slow_margin;
        logic [CPOS_W-1:0]  in_slow_zone;
        logic [TIMER_W-1:0] hold_time_ms;
        logic [TIMER_W-1:0] out_settle_ms;
    } cfg_t;

    typedef struct packed {
        logic                      drive_mode;
        logic signed [POWER_W-1:0] drive_power;
        logic [CPOS_W-1:0]         target_position;
        logic [MODE_W-1:0]         lift_mode;
    } result_t;

    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
                                                   input logic [TICK_W-1:0] d);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + {{(TIMER_W + 1 - TICK_W){1'b0}}, d};
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

endpackage

// ===== rtl/lthc_core.sv =====
// controller state registers and the per-tick decision logic
`timescale 1ns / 1ps

module lthc_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step_en,
    input  lthc_pkg::cfg_t                        cfg,
    input  logic                                  button_pressed,
    input  logic signed [lthc_pkg::POS_W-1:0]     lift_position,
    input  logic signed [lthc_pkg::VEL_W-1:0]     lift_velocity,
    output lthc_pkg::result_t                     result
);

    logic                               want_up_reg, want_up_next;
    logic                               at_neutral_reg, at_neutral_next;
    logic                               press_lock_reg, press_lock_next;
    logic                               up_latched_reg, up_latched_next;
    logic [lthc_pkg::TIMER_W-1:0]       hold_timer_reg, hold_timer_next;
    logic [lthc_pkg::TIMER_W-1:0]       out_timer_reg, out_timer_next;

    logic signed [lthc_pkg::POS_W:0]    pos_ext;
    logic signed [lthc_pkg::POS_W:0]    slow_zone_ext;
    logic signed [lthc_pkg::POS_W:0]    out_limit;
    logic [lthc_pkg::TIMER_W-1:0]       hold_sum;
    logic [lthc_pkg::TIMER_W-1:0]       out_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            want_up_reg    <= 1'b1;
            at_neutral_reg <= 1'b0;
            press_lock_reg <= 1'b0;
            up_latched_reg <= 1'b0;
            hold_timer_reg <= '0;
            out_timer_reg  <= '0;
        end else if (step_en) begin
            want_up_reg    <= want_up_next;
            at_neutral_reg <= at_neutral_next;
            press_lock_reg <= press_lock_next;
            up_latched_reg <= up_latched_next;
            hold_timer_reg <= hold_timer_next;
            out_timer_reg  <= out_timer_next;
        end
    end

    assign pos_ext       = {lift_position[lthc_pkg::POS_W-1], lift_position};
    assign slow_zone_ext = {2'b00, cfg.in_slow_zone};
    assign out_limit     = $signed({2'b00, cfg.out_position})
                         - $signed({2'b00, cfg.out_slow_margin});
    assign hold_sum      = lthc_pkg::sat_add(hold_timer_reg, cfg.tick_ms);
    assign out_sum       = lthc_pkg::sat_add(out_timer_reg, cfg.tick_ms);

    always_comb begin
        want_up_next    = want_up_reg;
        at_neutral_next = at_neutral_reg;
        press_lock_next = press_lock_reg;
        up_latched_next = up_latched_reg;
        hold_timer_next = hold_timer_reg;
        out_timer_next  = out_timer_reg;

        result.drive_mode      = lthc_pkg::DRIVE_POWER;
        result.drive_power     = lthc_pkg::PWR_STOP;
        result.target_position = '0;
        result.lift_mode       = lthc_pkg::LIFT_UP;

        // button handling
        if (button_pressed && !press_lock_reg) begin
            want_up_next    = at_neutral_reg ? 1'b0 : !want_up_reg;
            at_neutral_next = 1'b0;
            press_lock_next = 1'b1;
        end else if (button_pressed) begin
            if (want_up_reg) begin
                hold_timer_next = hold_sum;
                if (hold_sum >= cfg.hold_time_ms) begin
                    at_neutral_next = 1'b1;
                end
            end
        end else begin
            press_lock_next = 1'b0;
            hold_timer_next = '0;
        end

        // drive command
        if (at_neutral_next) begin
            result.drive_mode      = lthc_pkg::DRIVE_TARGET;
            result.target_position = cfg.neutral_position;
            result.lift_mode       = lthc_pkg::LIFT_NEUTRAL;
        end else if (want_up_next) begin
            result.lift_mode = lthc_pkg::LIFT_UP;
            if (pos_ext < slow_zone_ext) begin
                if (lift_velocity == '0 || lift_position < 0) begin
                    up_latched_next    = 1'b1;
                    result.drive_power = lthc_pkg::PWR_STOP;
                end else begin
                    result.drive_power = up_latched_reg ? lthc_pkg::PWR_STOP
                                                        : lthc_pkg::PWR_UP_SLOW;
                end
            end else begin
                up_latched_next    = 1'b0;
                result.drive_power = lthc_pkg::PWR_UP_FAST;
            end
        end else begin
            result.lift_mode = lthc_pkg::LIFT_OUT;
            if (pos_ext > out_limit) begin
                if (lift_velocity == '0) begin
                    result.drive_power = lthc_pkg::PWR_STOP;
                end else begin
                    out_timer_next     = out_sum;
                    result.drive_power = (out_sum < cfg.out_settle_ms)
                                       ? lthc_pkg::PWR_OUT_SLOW : lthc_pkg::PWR_STOP;
                end
            end else begin
                result.drive_power = lthc_pkg::PWR_OUT_FAST;
                out_timer_next     = '0;
            end
        end
    end

endmodule

// ===== rtl/lift_toggle_hold_controller_top.sv =====
// top level of the lift toggle/hold controller: request pipeline and config registers
`timescale 1ns / 1ps

// Takes one sensor tick per request (button level, lift position, lift
// velocity) and returns one drive command per request, in order. A new request
// is taken every clock cycle unless the result side stalls; each passes an input
// register, then the combinational decision logic, then a result register, and
// the controller state updates as its result is registered. Backpressure on the
// result side stalls both stages. The user must write configuration registers
// through cfg_wr_en / cfg_index / cfg_wdata only while no request is in flight;
// the block does not enforce this. An index above the last register is ignored
// and data is cut to the register's width.
module lift_toggle_hold_controller_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_button_pressed,
    input  logic signed [lthc_pkg::POS_W-1:0]      s_lift_position,
    input  logic signed [lthc_pkg::VEL_W-1:0]      s_lift_velocity,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_drive_mode,
    output logic signed [lthc_pkg::POWER_W-1:0]    m_drive_power,
    output logic [lthc_pkg::CPOS_W-1:0]            m_target_position,
    output logic [lthc_pkg::MODE_W-1:0]            m_lift_mode,

    input  logic                                   cfg_wr_en,
    input  logic [lthc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lthc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    lthc_pkg::cfg_t                        cfg_reg;

    logic                                  in_valid_reg;
    logic                                  in_button_reg;
    logic signed [lthc_pkg::POS_W-1:0]     in_position_reg;
    logic signed [lthc_pkg::VEL_W-1:0]     in_velocity_reg;

    logic                                  out_valid_reg;
    lthc_pkg::result_t                     out_result_reg;
    lthc_pkg::result_t                     step_result;

    logic                                  advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_ms          <= lthc_pkg::TICK_MS_RST;
            cfg_reg.neutral_position <= lthc_pkg::NEUTRAL_POSITION_RST;
            cfg_reg.out_position     <= lthc_pkg::OUT_POSITION_RST;
            cfg_reg.out_slow_margin  <= lthc_pkg::OUT_SLOW_MARGIN_RST;
            cfg_reg.in_slow_zone     <= lthc_pkg::IN_SLOW_ZONE_RST;
            cfg_reg.hold_time_ms     <= lthc_pkg::HOLD_TIME_MS_RST;
            cfg_reg.out_settle_ms    <= lthc_pkg::OUT_SETTLE_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lthc_pkg::REG_TICK_MS: begin
                    cfg_reg.tick_ms <= cfg_wdata[lthc_pkg::TICK_W-1:0];
                end
                lthc_pkg::REG_NEUTRAL_POSITION: begin
                    cfg_reg.neutral_position <= cfg_wdata[lthc_pkg::CPOS_W-1:0];
                end
                lthc_pkg::REG_OUT_POSITION: begin
                    cfg_reg.out_position <= cfg_wdata[lthc_pkg::CPOS_W-1:0];
                end
                lthc_pkg::REG_OUT_SLOW_MARGIN: begin
                    cfg_reg.out_slow_margin <= cfg_wdata[lthc_pkg::CPOS_W-1:0];
                end
                lthc_pkg::REG_IN_SLOW_ZONE: begin
                    cfg_reg.in_slow_zone <= cfg_wdata[lthc_pkg::CPOS_W-1:0];
                end
                lthc_pkg::REG_HOLD_TIME_MS: begin
                    cfg_reg.hold_time_ms <= cfg_wdata[lthc_pkg::TIMER_W-1:0];
                end
                lthc_pkg::REG_OUT_SETTLE_MS: begin
                    cfg_reg.out_settle_ms <= cfg_wdata[lthc_pkg::TIMER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_button_reg   <= s_button_pressed;
            in_position_reg <= s_lift_position;
            in_velocity_reg <= s_lift_velocity;
        end
    end

    lthc_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .cfg            (cfg_reg),
        .button_pressed (in_button_reg),
        .lift_position  (in_position_reg),
        .lift_velocity  (in_velocity_reg),
        .result         (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_drive_mode      = out_result_reg.drive_mode;
    assign m_drive_power     = out_result_reg.drive_power;
    assign m_target_position = out_result_reg.target_position;
    assign m_lift_mode       = out_result_reg.lift_mode;

endmodule

// ===== rtl/lthc_checker.sv =====
// port-level checker for the lift toggle/hold controller, bound to the top level
`timescale 1ns / 1ps

module lthc_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic                                   m_drive_mode,
    input  logic signed [lthc_pkg::POWER_W-1:0]    m_drive_power,
    input  logic [lthc_pkg::CPOS_W-1:0]            m_target_position,
    input  logic [lthc_pkg::MODE_W-1:0]            m_lift_mode
);

    // position command only in neutral, with no power
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_mode == lthc_pkg::DRIVE_TARGET
        |-> m_lift_mode == lthc_pkg::LIFT_NEUTRAL && m_drive_power == lthc_pkg::PWR_STOP)
        else $error("position command outside neutral or with power");

    // power command never carries a target and is never neutral
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_mode == lthc_pkg::DRIVE_POWER
        |-> m_target_position == '0 && m_lift_mode != lthc_pkg::LIFT_NEUTRAL)
        else $error("power command with target or neutral mode");

    // up drives only at the up levels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lift_mode == lthc_pkg::LIFT_UP
        |-> m_drive_power == lthc_pkg::PWR_STOP || m_drive_power == lthc_pkg::PWR_UP_SLOW
            || m_drive_power == lthc_pkg::PWR_UP_FAST)
        else $error("bad power while up");

    // out drives only at the out levels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lift_mode == lthc_pkg::LIFT_OUT
        |-> m_drive_power == lthc_pkg::PWR_STOP || m_drive_power == lthc_pkg::PWR_OUT_SLOW
            || m_drive_power == lthc_pkg::PWR_OUT_FAST)
        else $error("bad power while out");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready
        |=> m_valid && $stable(m_drive_mode) && $stable(m_drive_power)
            && $stable(m_target_position) && $stable(m_lift_mode))
        else $error("stalled result changed");

endmodule

bind lift_toggle_hold_controller_top lthc_checker u_lthc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_drive_mode      (m_drive_mode),
    .m_drive_power     (m_drive_power),
    .m_target_position (m_target_position),
    .m_lift_mode       (m_lift_mode)
);
